// ----- rtl/core/gke_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gke_pkg
// Shared widths, limits and sequencer state codes of the knapsack estimator.
// ----------------------------------------------------------------------------
package gke_pkg;

  localparam int COST_W   = 16;
  localparam int WEIGHT_W = 16;
  localparam int CAP_W    = 22;
  localparam int VALUE_W  = 22;
  localparam int PROD_W   = COST_W + WEIGHT_W;
  localparam int WSUM_W   = 24;
  localparam logic [VALUE_W-1:0] VALUE_MAX = 22'h3FFFFF;

  typedef enum logic [16:0] {
    ST_LOAD      = 17'b00000000000000001,
    ST_SORT_CUR  = 17'b00000000000000010,
    ST_SORT_CLD  = 17'b00000000000000100,
    ST_SORT_RK   = 17'b00000000000001000,
    ST_SORT_RLD  = 17'b00000000000010000,
    ST_SORT_MUL1 = 17'b00000000000100000,
    ST_SORT_MUL2 = 17'b00000000001000000,
    ST_SORT_CMP  = 17'b00000000010000000,
    ST_SORT_PUT  = 17'b00000000100000000,
    ST_WALK_ANC  = 17'b00000001000000000,
    ST_WALK_ALD  = 17'b00000010000000000,
    ST_WALK_ADAT = 17'b00000100000000000,
    ST_WALK_TEST = 17'b00001000000000000,
    ST_WALK_RLD  = 17'b00010000000000000,
    ST_WALK_ADD  = 17'b00100000000000000,
    ST_WALK_DONE = 17'b01000000000000000,
    ST_FINISH    = 17'b10000000000000000
  } gke_state_t;

endpackage

// ----- rtl/core/gke_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gke item and result channels
// Valid/ready channels carrying one item request and one estimate result.
// ----------------------------------------------------------------------------
interface gke_item_if import gke_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COST_W-1:0]   item_cost;
  logic [WEIGHT_W-1:0] item_weight;
  logic                last_item;

  modport source (output valid, item_cost, item_weight, last_item, input ready);
  modport sink   (input valid, item_cost, item_weight, last_item, output ready);
endinterface

interface gke_result_if import gke_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] best_value;
  logic               overflow;

  modport source (output valid, best_value, overflow, input ready);
  modport sink   (input valid, best_value, overflow, output ready);
endinterface

// ----- rtl/core/gke_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gke_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gke_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/greedy_knapsack_estimator.sv -----
`timescale 1ns / 1ps
// Operation: each item request is taken while loading; the request flagged last starts
// the estimate. Ranking of the n items is an insertion sort with c ratio compares, at
// most I + n - 1 for I inversions; one shared 16x16 multiplier is used twice per compare.
// The walk then tries each ranked item as anchor and adds items from the top rank down.
// Throughput: one problem at a time; no request is taken while estimating.
// Reset: synchronous, clears counts, best value, overflow flag and capacity.
// ----------------------------------------------------------------------------
// greedy_knapsack_estimator
// Ranks loaded items by cost/weight ratio and takes the best greedy fill.
// ----------------------------------------------------------------------------
module greedy_knapsack_estimator import gke_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CAP_W-1:0]   cfg_wr_data,
  gke_item_if.sink           item,
  gke_result_if.source       result
);

  localparam int AW     = $clog2(MAX_ITEMS);
  localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam int CSUM_R = COST_W + AW;
  localparam int SUM_W  = (CSUM_R > VALUE_W + 1) ? CSUM_R : VALUE_W + 1;

  gke_state_t state;

  // Control state
  logic [CAP_W-1:0]    capacity;
  logic [CNT_W-1:0]    item_count;
  logic                dropped;
  logic [CNT_W-1:0]    i_idx, k_idx, j_idx, r_idx;
  logic                res_valid;

  // Working registers
  logic [COST_W-1:0]   cur_cost;
  logic [WEIGHT_W-1:0] cur_weight;
  logic [WEIGHT_W-1:0] prev_weight;
  logic [AW-1:0]       prev_rank;
  logic [PROD_W-1:0]   lhs, rhs;
  logic [WEIGHT_W-1:0] anchor_weight;
  logic [WSUM_W-1:0]   wsum;
  logic [SUM_W-1:0]    csum;
  logic [SUM_W-1:0]    best;
  logic [VALUE_W-1:0]  res_value;
  logic                res_overflow;

  // RAM ports
  logic                cw_we;
  logic [AW-1:0]       cw_waddr, cw_raddr;
  logic [COST_W-1:0]   cost_rdata;
  logic [WEIGHT_W-1:0] weight_rdata;
  logic                rk_we;
  logic [AW-1:0]       rk_waddr, rk_wdata, rk_raddr;
  logic [AW-1:0]       rank_rdata;

  // Shared multiplier and helpers
  logic [COST_W-1:0]   mul_a;
  logic [WEIGHT_W-1:0] mul_b;
  logic [PROD_W-1:0]   mul_p;
  logic [CNT_W-1:0]    k_dec, r_dec, i_inc, j_inc;
  logic [WSUM_W-1:0]   fill_test;
  logic                item_acc, res_free;

  assign k_dec = k_idx - CNT_W'(1);
  assign r_dec = r_idx - CNT_W'(1);
  assign i_inc = i_idx + CNT_W'(1);
  assign j_inc = j_idx + CNT_W'(1);
  assign fill_test = wsum + WSUM_W'(anchor_weight);

  assign item.ready  = (state == ST_LOAD);
  assign item_acc    = item.valid && item.ready;
  assign res_free    = !res_valid || result.ready;

  assign result.valid      = res_valid;
  assign result.best_value = res_value;
  assign result.overflow   = res_overflow;

  // One multiplier serves both sides of the cross-multiplied ratio compare
  always_comb begin
    if (state == ST_SORT_MUL1) begin
      mul_a = cost_rdata;
      mul_b = cur_weight;
    end else begin
      mul_a = cur_cost;
      mul_b = prev_weight;
    end
    mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  // Store writes take the next free slot while loading
  assign cw_we    = item_acc && (item_count < CNT_W'(MAX_ITEMS));
  assign cw_waddr = item_count[AW-1:0];

  always_comb begin
    case (state)
      ST_SORT_CUR: cw_raddr = i_idx[AW-1:0];
      ST_SORT_RLD,
      ST_WALK_ALD,
      ST_WALK_RLD: cw_raddr = rank_rdata;
      default:     cw_raddr = '0;
    endcase
  end

  always_comb begin
    case (state)
      ST_SORT_RK:   rk_raddr = k_dec[AW-1:0];
      ST_WALK_ANC:  rk_raddr = j_idx[AW-1:0];
      ST_WALK_TEST: rk_raddr = r_dec[AW-1:0];
      default:      rk_raddr = '0;
    endcase
  end

  // Shift a higher-ratio entry up, or drop the current item into its slot
  always_comb begin
    rk_waddr = k_idx[AW-1:0];
    rk_we    = 1'b0;
    rk_wdata = i_idx[AW-1:0];
    if (state == ST_SORT_CMP && lhs > rhs) begin
      rk_we    = 1'b1;
      rk_wdata = prev_rank;
    end else if (state == ST_SORT_PUT) begin
      rk_we    = 1'b1;
    end
  end

  gke_ram #(.WIDTH(COST_W), .DEPTH(MAX_ITEMS)) u_cost_ram (
    .clk(clk), .we(cw_we), .waddr(cw_waddr), .wdata(item.item_cost),
    .raddr(cw_raddr), .rdata(cost_rdata)
  );

  gke_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_ITEMS)) u_weight_ram (
    .clk(clk), .we(cw_we), .waddr(cw_waddr), .wdata(item.item_weight),
    .raddr(cw_raddr), .rdata(weight_rdata)
  );

  gke_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_rank_ram (
    .clk(clk), .we(rk_we), .waddr(rk_waddr), .wdata(rk_wdata),
    .raddr(rk_raddr), .rdata(rank_rdata)
  );

  // Capacity register: the user must write it only while idle; the block does not enforce this
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= '0;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  // Payload of the working loops
  always_ff @(posedge clk) begin
    case (state)
      ST_SORT_CLD: begin
        cur_cost   <= cost_rdata;
        cur_weight <= weight_rdata;
      end
      ST_SORT_RLD: prev_rank <= rank_rdata;
      ST_SORT_MUL1: begin
        lhs         <= mul_p;
        prev_weight <= weight_rdata;
      end
      ST_SORT_MUL2: rhs <= mul_p;
      ST_WALK_ADAT: begin
        anchor_weight <= weight_rdata;
        csum          <= SUM_W'(cost_rdata);
        wsum          <= '0;
      end
      ST_WALK_ADD: begin
        wsum <= wsum + WSUM_W'(weight_rdata);
        csum <= csum + SUM_W'(cost_rdata);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_LOAD;
      item_count   <= '0;
      dropped      <= 1'b0;
      best         <= '0;
      i_idx        <= '0;
      k_idx        <= '0;
      j_idx        <= '0;
      r_idx        <= '0;
      res_valid    <= 1'b0;
      res_value    <= '0;
      res_overflow <= 1'b0;
    end else begin
      // Drop the taken result, unless a new one is posted in the same cycle
      if (res_valid && result.ready && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_LOAD: begin
          if (item_acc) begin
            if (cw_we) begin
              item_count <= item_count + CNT_W'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (item.last_item) begin
              i_idx <= '0;
              state <= ST_SORT_CUR;
            end
          end
        end
        ST_SORT_CUR: state <= ST_SORT_CLD;
        ST_SORT_CLD: begin
          // Largest single cost seeds the best value
          if (SUM_W'(cost_rdata) > best) begin
            best <= SUM_W'(cost_rdata);
          end
          k_idx <= i_idx;
          state <= (i_idx == '0) ? ST_SORT_PUT : ST_SORT_RK;
        end
        ST_SORT_RK:   state <= ST_SORT_RLD;
        ST_SORT_RLD:  state <= ST_SORT_MUL1;
        ST_SORT_MUL1: state <= ST_SORT_MUL2;
        ST_SORT_MUL2: state <= ST_SORT_CMP;
        ST_SORT_CMP: begin
          // Strictly greater ratio moves up; ties hold arrival order
          if (lhs > rhs) begin
            k_idx <= k_dec;
            state <= (k_dec == '0) ? ST_SORT_PUT : ST_SORT_RK;
          end else begin
            state <= ST_SORT_PUT;
          end
        end
        ST_SORT_PUT: begin
          i_idx <= i_inc;
          if (i_inc == item_count) begin
            j_idx <= '0;
            state <= ST_WALK_ANC;
          end else begin
            state <= ST_SORT_CUR;
          end
        end
        ST_WALK_ANC: state <= ST_WALK_ALD;
        ST_WALK_ALD: state <= ST_WALK_ADAT;
        ST_WALK_ADAT: begin
          r_idx <= item_count;
          state <= ST_WALK_TEST;
        end
        ST_WALK_TEST: begin
          // Walk down from the top rank, skipping the anchor's own slot
          if (r_idx == '0) begin
            state <= ST_WALK_DONE;
          end else if (r_dec == j_idx) begin
            r_idx <= r_dec;
          end else if (fill_test >= WSUM_W'(capacity)) begin
            state <= ST_WALK_DONE;
          end else begin
            r_idx <= r_dec;
            state <= ST_WALK_RLD;
          end
        end
        ST_WALK_RLD: state <= ST_WALK_ADD;
        ST_WALK_ADD: state <= ST_WALK_TEST;
        ST_WALK_DONE: begin
          if (csum > best) begin
            best <= csum;
          end
          j_idx <= j_inc;
          state <= (j_inc == item_count) ? ST_FINISH : ST_WALK_ANC;
        end
        ST_FINISH: begin
          // Hold until the result register is free, then clear the problem
          if (res_free) begin
            res_valid    <= 1'b1;
            res_value    <= (best > SUM_W'(VALUE_MAX)) ? VALUE_MAX : best[VALUE_W-1:0];
            res_overflow <= dropped;
            item_count   <= '0;
            dropped      <= 1'b0;
            best         <= '0;
            state        <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule
